// File: hw/rtl/pcid_pkg.sv
`default_nettype none

package pcid_pkg;

   localparam int FUNCTION_COUNT_DEFAULT = 1;
   localparam int WORDS_PER_FUNCTION     = 64;
   localparam int FULL_INDEX_W           = 14;

   localparam logic [31:0] PORT_ADDRESS = 32'h0000_0cf8;
   localparam logic [31:0] PORT_DATA    = 32'h0000_0cfc;
   localparam logic [31:0] PORT_RESET   = 32'h0000_0cf9;

   localparam logic [7:0]  OPC_OUT32    = 8'hef;
   localparam logic [7:0]  OPC_OUT8     = 8'hee;
   localparam logic [7:0]  OPC_OUT8_IMM = 8'he6;
   localparam logic [7:0]  OPC_IN8      = 8'hec;
   localparam logic [7:0]  OPC_IN32     = 8'hed;
   localparam logic [15:0] OPC_OUT16    = 16'hef66;
   localparam logic [15:0] OPC_PIC_IN   = 16'h21e4;
   localparam logic [15:0] OPC_IN16     = 16'hed66;

   localparam logic [31:0] BRIDGE_ID_WORD0 = 32'h7190_8086;
   localparam logic [31:0] BRIDGE_ID_WORD1 = 32'h0200_0006;
   localparam logic [31:0] BRIDGE_ID_WORD2 = 32'h0600_0001;
   localparam logic [31:0] ABSENT_WORD     = 32'hffff_ffff;
   localparam logic [31:0] PIC_MASK        = 32'h0000_00ff;

   localparam logic [1:0] EXIT_CONTINUE = 2'd0;
   localparam logic [1:0] EXIT_STOP     = 2'd1;
   localparam logic [1:0] EXIT_RESET    = 2'd2;

   // command classes handed from front to back
   localparam logic [3:0] OP_NOP        = 4'd0;
   localparam logic [3:0] OP_SET_ADDR   = 4'd1;
   localparam logic [3:0] OP_WRITE_WORD = 4'd2;
   localparam logic [3:0] OP_RESET_REQ  = 4'd3;
   localparam logic [3:0] OP_READ8      = 4'd4;
   localparam logic [3:0] OP_READ16     = 4'd5;
   localparam logic [3:0] OP_READ32     = 4'd6;
   localparam logic [3:0] OP_READ_ADDR  = 4'd7;
   localparam logic [3:0] OP_PIC        = 4'd8;
   localparam logic [3:0] OP_STOP       = 4'd9;

   typedef struct packed {
      logic [7:0]  first_opcode_byte;
      logic [7:0]  second_opcode_byte;
      logic [31:0] port_number;
      logic [31:0] accumulator_in;
   } req_type;

   typedef struct packed {
      logic [31:0] accumulator_out;
      logic        accumulator_write;
      logic [1:0]  exit_status;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [1:0]  byte_shift;
      logic [31:0] acc;
   } cmd_type;

   function automatic logic [31:0] init_word(input logic [FULL_INDEX_W-1:0] idx);
      logic [31:0] w;
      unique case (idx)
         14'd0:   w = BRIDGE_ID_WORD0;
         14'd1:   w = BRIDGE_ID_WORD1;
         14'd2:   w = BRIDGE_ID_WORD2;
         default: w = 32'h0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pcid_front.sv
`default_nettype none

module pcid_front (
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pcid_pkg::req_type req_data,
   input  wire logic             store_ready,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready,
   output pcid_pkg::cmd_type     cmd_data
);

   logic [15:0] op16;
   logic [7:0]  b0;
   logic [31:0] port;
   logic [31:0] acc;
   logic [3:0]  op;
   logic [1:0]  shift;

   assign b0   = req_data.first_opcode_byte;
   assign op16 = {req_data.second_opcode_byte, req_data.first_opcode_byte};
   assign port = req_data.port_number;
   assign acc  = req_data.accumulator_in;

   always_comb begin
      shift = 2'd0;
      priority if (b0 == pcid_pkg::OPC_OUT32) begin
         if (port == pcid_pkg::PORT_ADDRESS)   op = pcid_pkg::OP_SET_ADDR;
         else if (port == pcid_pkg::PORT_DATA) op = pcid_pkg::OP_WRITE_WORD;
         else                                  op = pcid_pkg::OP_NOP;
      end else if (b0 == pcid_pkg::OPC_OUT8) begin
         if (port == pcid_pkg::PORT_RESET && acc[2]) op = pcid_pkg::OP_RESET_REQ;
         else                                        op = pcid_pkg::OP_NOP;
      end else if (b0 == pcid_pkg::OPC_OUT8_IMM) begin
         op = pcid_pkg::OP_NOP;
      end else if (op16 == pcid_pkg::OPC_OUT16) begin
         op = pcid_pkg::OP_NOP;
      end else if (b0 == pcid_pkg::OPC_IN8) begin
         op    = pcid_pkg::OP_READ8;
         shift = port[1:0];
      end else if (b0 == pcid_pkg::OPC_IN32) begin
         if (port == pcid_pkg::PORT_ADDRESS) op = pcid_pkg::OP_READ_ADDR;
         else                                op = pcid_pkg::OP_READ32;
      end else if (op16 == pcid_pkg::OPC_PIC_IN) begin
         op = pcid_pkg::OP_PIC;
      end else if (op16 == pcid_pkg::OPC_IN16) begin
         op    = pcid_pkg::OP_READ16;
         shift = {port[1], 1'b0};
      end else begin
         op = pcid_pkg::OP_STOP;
      end
   end

   // hold off the host until the store sweep after reset is over
   assign req_ready = cmd_ready && store_ready && !reset;
   assign cmd_valid = req_valid && store_ready && !reset;
   assign cmd_data  = {op, shift, acc};

endmodule

`default_nettype wire

// File: hw/rtl/pcid_queue.sv
`default_nettype none

module pcid_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire pcid_pkg::cmd_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output pcid_pkg::cmd_type      out_data
);

   pcid_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_data;
   end

endmodule

`default_nettype wire

// File: hw/rtl/pcid_back.sv
`default_nettype none

module pcid_back #(
   parameter int FUNCTION_COUNT = pcid_pkg::FUNCTION_COUNT_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire pcid_pkg::cmd_type cmd_data,
   output logic                   store_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pcid_pkg::rsp_type      rsp_data
);

   localparam int DEPTH = FUNCTION_COUNT * pcid_pkg::WORDS_PER_FUNCTION;
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [8:0] FN_LIMIT = 9'(FUNCTION_COUNT);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [31:0] addr_ff, addr_in;
   logic        present_ff, present_in;
   logic [1:0]  shift_ff, shift_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pcid_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] mem_rdata_ff;
   logic        mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [31:0] mem_wdata;

   logic [pcid_pkg::FULL_INDEX_W-1:0] full_idx;
   logic [pcid_pkg::FULL_INDEX_W-1:0] clr_full;
   logic [IDX_W-1:0] idx;
   logic        present;
   logic        out_free;
   logic        pop;
   logic [31:0] rd_word;

   // function in bits 15..8, word in bits 7..2
   assign full_idx = {addr_ff[15:8], addr_ff[7:2]};
   assign idx      = full_idx[IDX_W-1:0];
   assign present  = ({1'b0, addr_ff[15:8]} < FN_LIMIT);
   assign clr_full = pcid_pkg::FULL_INDEX_W'(clr_cnt_ff);

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign cmd_ready   = (state_ff == ST_RUN) && out_free;
   assign pop         = cmd_valid && cmd_ready;
   assign store_ready = (state_ff != ST_CLEAR);
   assign rd_word     = present_ff ? mem_rdata_ff : pcid_pkg::ABSENT_WORD;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      addr_in      = addr_ff;
      present_in   = present_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx;
      mem_wdata    = cmd_data.acc;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = pcid_pkg::init_word(clr_full);
            if (clr_cnt_ff == LAST_IDX) state_in = ST_RUN;
            else clr_cnt_in = clr_cnt_ff + IDX_W'(1);
         end
         ST_RUN: begin
            if (pop) begin
               rsp_data_in.accumulator_out   = 32'h0;
               rsp_data_in.accumulator_write = 1'b0;
               rsp_data_in.exit_status       = pcid_pkg::EXIT_CONTINUE;
               present_in = present;
               shift_in   = cmd_data.byte_shift;
               unique case (cmd_data.op)
                  pcid_pkg::OP_SET_ADDR: begin
                     addr_in      = cmd_data.acc;
                     rsp_valid_in = 1'b1;
                  end
                  pcid_pkg::OP_WRITE_WORD: begin
                     mem_we       = present;
                     rsp_valid_in = 1'b1;
                  end
                  pcid_pkg::OP_RESET_REQ: begin
                     rsp_data_in.exit_status = pcid_pkg::EXIT_RESET;
                     rsp_valid_in            = 1'b1;
                  end
                  pcid_pkg::OP_READ8, pcid_pkg::OP_READ16, pcid_pkg::OP_READ32: begin
                     state_in = ST_WAIT;
                  end
                  pcid_pkg::OP_READ_ADDR: begin
                     rsp_data_in.accumulator_out   = addr_ff;
                     rsp_data_in.accumulator_write = 1'b1;
                     rsp_valid_in                  = 1'b1;
                  end
                  pcid_pkg::OP_PIC: begin
                     rsp_data_in.accumulator_out   = cmd_data.acc | pcid_pkg::PIC_MASK;
                     rsp_data_in.accumulator_write = 1'b1;
                     rsp_valid_in                  = 1'b1;
                  end
                  pcid_pkg::OP_STOP: begin
                     rsp_data_in.exit_status = pcid_pkg::EXIT_STOP;
                     rsp_valid_in            = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WAIT: begin
            // output register is empty here: the pop only happened with it free
            rsp_data_in.accumulator_out   = rd_word >> {shift_ff, 3'b000};
            rsp_data_in.accumulator_write = 1'b1;
            rsp_data_in.exit_status       = pcid_pkg::EXIT_CONTINUE;
            rsp_valid_in                  = 1'b1;
            state_in                      = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         addr_ff      <= 32'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      present_ff  <= present_in;
      shift_ff    <= shift_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem_ff[idx];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pci_config_io_port_decoder.sv
`default_nettype none

// channel | direction | handshake             | word
// req     | in        | req_valid / req_ready | pcid_pkg::req_type (opcode bytes, DX, EAX)
// rsp     | out       | rsp_valid / rsp_ready | pcid_pkg::rsp_type (EAX, write flag, exit)
//
// One word per access. Writes and non-store accesses pass the queue and the registered
// rsp word; store reads also pass the ST_WAIT state (registered read port of the word
// store). The back end runs one access at a time and takes no new access while a store
// read waits in ST_WAIT. After reset the word store is swept to its power-on contents,
// FUNCTION_COUNT*64 words, with req_ready low. A stalled rsp holds the back end; the
// two-entry queue keeps accepting until full.

module pci_config_io_port_decoder #(
   parameter int FUNCTION_COUNT = pcid_pkg::FUNCTION_COUNT_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pcid_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pcid_pkg::rsp_type      rsp_data
);

   logic              front_valid, front_ready;
   pcid_pkg::cmd_type front_cmd;
   logic              back_valid, back_ready;
   pcid_pkg::cmd_type back_cmd;
   logic              store_ready;

   pcid_front u_front (
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .store_ready (store_ready),
      .cmd_valid   (front_valid),
      .cmd_ready   (front_ready),
      .cmd_data    (front_cmd)
   );

   pcid_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_cmd)
   );

   pcid_back #(
      .FUNCTION_COUNT (FUNCTION_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (back_valid),
      .cmd_ready   (back_ready),
      .cmd_data    (back_cmd),
      .store_ready (store_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// File: hw/rtl/pcid_checker.sv
`default_nettype none

module pcid_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire pcid_pkg::rsp_type rsp_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // the store sweep keeps the host off right after reset
   a_sweep_blocks: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req accepted during store sweep");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accumulator_write |-> rsp_data.accumulator_out == 32'h0)
      else $error("accumulator_out nonzero without write");

   a_write_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accumulator_write |->
         rsp_data.exit_status == pcid_pkg::EXIT_CONTINUE)
      else $error("accumulator write with exit status");

   a_exit_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.exit_status <= pcid_pkg::EXIT_RESET)
      else $error("exit status out of range");

endmodule

bind pci_config_io_port_decoder pcid_checker u_pcid_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: bench/pcid_checker.sv
`timescale 1ns / 1ps

module pcid_scoreboard #(
   parameter int FUNCTION_COUNT = pcid_pkg::FUNCTION_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  pcid_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  pcid_pkg::rsp_type rsp_data,
   output int                failures,
   output int                pending,
   output int                checked,
   output int                store_writes,
   output int                store_reads,
   output int                reset_requests,
   output int                stops
);

   localparam int STORE_DEPTH = FUNCTION_COUNT * pcid_pkg::WORDS_PER_FUNCTION;

   logic [31:0]       cfg_addr;
   logic [31:0]       cfg_words [STORE_DEPTH];
   pcid_pkg::rsp_type awaited_rsp [$];

   // -1 when the addressed function does not exist
   function automatic int store_index();
      int fn;
      fn = int'(cfg_addr[15:8]);
      if (fn >= FUNCTION_COUNT) return -1;
      return fn * pcid_pkg::WORDS_PER_FUNCTION + int'(cfg_addr[7:2]);
   endfunction

   function automatic logic [31:0] fetch_word();
      int idx;
      idx = store_index();
      store_reads++;
      return (idx < 0) ? pcid_pkg::ABSENT_WORD : cfg_words[idx];
   endfunction

   // decode one access in priority order and update the register and store
   function automatic pcid_pkg::rsp_type decode_access(input pcid_pkg::req_type a);
      pcid_pkg::rsp_type r;
      logic [15:0]       op16;
      int                idx;
      r    = '0;
      op16 = {a.second_opcode_byte, a.first_opcode_byte};
      if (a.first_opcode_byte == pcid_pkg::OPC_OUT32) begin
         if (a.port_number == pcid_pkg::PORT_ADDRESS) begin
            cfg_addr = a.accumulator_in;
         end else if (a.port_number == pcid_pkg::PORT_DATA) begin
            idx = store_index();
            if (idx >= 0) cfg_words[idx] = a.accumulator_in;
            store_writes++;
         end
      end else if (a.first_opcode_byte == pcid_pkg::OPC_OUT8) begin
         if (a.port_number == pcid_pkg::PORT_RESET && a.accumulator_in[2])
            r.exit_status = pcid_pkg::EXIT_RESET;
      end else if (a.first_opcode_byte == pcid_pkg::OPC_OUT8_IMM ||
                   op16 == pcid_pkg::OPC_OUT16) begin
         // drop silently
      end else if (a.first_opcode_byte == pcid_pkg::OPC_IN8) begin
         r.accumulator_out   = fetch_word() >> {a.port_number[1:0], 3'b000};
         r.accumulator_write = 1'b1;
      end else if (a.first_opcode_byte == pcid_pkg::OPC_IN32) begin
         r.accumulator_out   = (a.port_number == pcid_pkg::PORT_ADDRESS) ? cfg_addr
                                                                         : fetch_word();
         r.accumulator_write = 1'b1;
      end else if (op16 == pcid_pkg::OPC_PIC_IN) begin
         r.accumulator_out   = a.accumulator_in | pcid_pkg::PIC_MASK;
         r.accumulator_write = 1'b1;
      end else if (op16 == pcid_pkg::OPC_IN16) begin
         r.accumulator_out   = fetch_word() >> {a.port_number[1], 4'b0000};
         r.accumulator_write = 1'b1;
      end else begin
         r.exit_status = pcid_pkg::EXIT_STOP;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      pcid_pkg::rsp_type want;
      pcid_pkg::rsp_type got;
      if (reset) begin
         cfg_addr = '0;
         for (int i = 0; i < STORE_DEPTH; i++) cfg_words[i] = '0;
         cfg_words[0] = pcid_pkg::BRIDGE_ID_WORD0;
         cfg_words[1] = pcid_pkg::BRIDGE_ID_WORD1;
         cfg_words[2] = pcid_pkg::BRIDGE_ID_WORD2;
         awaited_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (awaited_rsp.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("pcid_scoreboard: word with none awaited: acc %h wr %b exit %0d",
                           got.accumulator_out, got.accumulator_write, got.exit_status);
            end else begin
               want = awaited_rsp.pop_front();
               checked++;
               if (got.accumulator_out !== want.accumulator_out ||
                   got.accumulator_write !== want.accumulator_write ||
                   got.exit_status !== want.exit_status) begin
                  failures++;
                  if (failures <= 10)
                     $display({"pcid_scoreboard: word %0d: expected acc %h wr %b exit %0d,",
                               " got acc %h wr %b exit %0d"}, checked,
                              want.accumulator_out, want.accumulator_write,
                              want.exit_status, got.accumulator_out,
                              got.accumulator_write, got.exit_status);
               end
            end
         end
         if (req_valid && req_ready) begin
            want = decode_access(req_data);
            if (want.exit_status == pcid_pkg::EXIT_RESET) reset_requests++;
            if (want.exit_status == pcid_pkg::EXIT_STOP) stops++;
            awaited_rsp.push_back(want);
         end
      end
      pending = awaited_rsp.size();
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int FUNCS        = pcid_pkg::FUNCTION_COUNT_DEFAULT;
   localparam int ACCESS_COUNT = 1750;
   localparam int PRESSURE_AT  = 500;   // responses taken before the long hold-off
   localparam int PRESSURE_LEN = 200;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   pcid_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   pcid_pkg::rsp_type rsp_data;

   int failures;
   int pending;
   int checked;
   int store_writes;
   int store_reads;
   int reset_requests;
   int stops;
   int sent;
   int taken;
   int drain_wait;

   pci_config_io_port_decoder #(
      .FUNCTION_COUNT(FUNCS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   pcid_scoreboard #(
      .FUNCTION_COUNT(FUNCS)
   ) chk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .failures      (failures),
      .pending       (pending),
      .checked       (checked),
      .store_writes  (store_writes),
      .store_reads   (store_reads),
      .reset_requests(reset_requests),
      .stops         (stops)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic int idle_cycles(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic pcid_pkg::req_type make_access(input logic [7:0] b0,
                                                     input logic [7:0] b1,
                                                     input logic [31:0] port,
                                                     input logic [31:0] acc);
      pcid_pkg::req_type a;
      a.first_opcode_byte  = b0;
      a.second_opcode_byte = b1;
      a.port_number        = port;
      a.accumulator_in     = acc;
      return a;
   endfunction

   // mostly well-formed config cycles around the window, some noise
   function automatic pcid_pkg::req_type draw_access();
      int          kind;
      logic [31:0] acc;
      logic [31:0] port;
      logic [7:0]  b1;
      kind = $urandom_range(0, 99);
      acc  = $urandom;
      b1   = 8'($urandom);
      port = ($urandom_range(0, 9) < 7) ? pcid_pkg::PORT_DATA + $urandom_range(0, 3)
                                        : $urandom;
      if (kind < 15) begin
         if ($urandom_range(0, 9) != 0) acc[15:8] = 8'($urandom_range(0, FUNCS - 1));
         return make_access(pcid_pkg::OPC_OUT32, b1, pcid_pkg::PORT_ADDRESS, acc);
      end else if (kind < 28) begin
         return make_access(pcid_pkg::OPC_OUT32, b1, pcid_pkg::PORT_DATA, acc);
      end else if (kind < 38) begin
         return make_access(pcid_pkg::OPC_IN8, b1, port, acc);
      end else if (kind < 48) begin
         return make_access(pcid_pkg::OPC_IN32, b1, port, acc);
      end else if (kind < 56) begin
         return make_access(pcid_pkg::OPC_IN16[7:0], pcid_pkg::OPC_IN16[15:8], port, acc);
      end else if (kind < 60) begin
         return make_access(pcid_pkg::OPC_IN32, b1, pcid_pkg::PORT_ADDRESS, acc);
      end else if (kind < 64) begin
         return make_access(pcid_pkg::OPC_PIC_IN[7:0], pcid_pkg::OPC_PIC_IN[15:8],
                            port, acc);
      end else if (kind < 70) begin
         if ($urandom_range(0, 1) == 0) port = pcid_pkg::PORT_RESET;
         return make_access(pcid_pkg::OPC_OUT8, b1, port, acc);
      end else if (kind < 73) begin
         return make_access(pcid_pkg::OPC_OUT8_IMM, b1, port, acc);
      end else if (kind < 76) begin
         return make_access(pcid_pkg::OPC_OUT16[7:0], pcid_pkg::OPC_OUT16[15:8],
                            port, acc);
      end else if (kind < 84) begin
         // prefix or PIC first byte with a wrong second byte
         return make_access(($urandom_range(0, 1) != 0) ? pcid_pkg::OPC_IN16[7:0]
                                                        : pcid_pkg::OPC_PIC_IN[7:0],
                            b1, port, acc);
      end else begin
         return make_access(8'($urandom), b1, $urandom, acc);
      end
   endfunction

   task automatic offer(input pcid_pkg::req_type w);
      int gap;
      gap = idle_cycles((sent % 400) >= 300);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!(req_valid && req_ready));
      sent++;
   endtask

   // response side: short random stalls, one long hold-off to back the block up
   initial begin
      int hold;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == PRESSURE_AT) hold = PRESSURE_LEN;
         else hold = idle_cycles((taken % 300) >= 220);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
      end
   end

   initial begin
      req_valid <= 1'b0;
      req_data  <= '0;
      reset     <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // identity words and lane shifts at power-on address
      offer(make_access(pcid_pkg::OPC_IN32, 8'h00, pcid_pkg::PORT_DATA, 32'h0));
      offer(make_access(pcid_pkg::OPC_IN8, 8'hff, pcid_pkg::PORT_DATA + 1, 32'hffff_ffff));
      offer(make_access(pcid_pkg::OPC_IN8, 8'h00, pcid_pkg::PORT_DATA + 3, 32'h0));
      offer(make_access(pcid_pkg::OPC_IN16[7:0], pcid_pkg::OPC_IN16[15:8],
                        pcid_pkg::PORT_DATA + 2, 32'h0));
      offer(make_access(pcid_pkg::OPC_IN32, 8'h00, pcid_pkg::PORT_ADDRESS, 32'h0));
      offer(make_access(pcid_pkg::OPC_OUT32, 8'h00, pcid_pkg::PORT_ADDRESS, 32'h0000_0008));
      offer(make_access(pcid_pkg::OPC_IN32, 8'h00, pcid_pkg::PORT_DATA, 32'h0));
      offer(make_access(pcid_pkg::OPC_OUT32, 8'h00, pcid_pkg::PORT_DATA, 32'hffff_ffff));
      offer(make_access(pcid_pkg::OPC_IN8, 8'h00, pcid_pkg::PORT_DATA + 3, 32'h0));
      // last word of the existing function
      offer(make_access(pcid_pkg::OPC_OUT32, 8'h00, pcid_pkg::PORT_ADDRESS, 32'h8000_00fc));
      offer(make_access(pcid_pkg::OPC_OUT32, 8'h00, pcid_pkg::PORT_DATA, 32'h0));
      offer(make_access(pcid_pkg::OPC_IN16[7:0], pcid_pkg::OPC_IN16[15:8],
                        pcid_pkg::PORT_DATA, 32'h0));
      // absent function: reads all ones, writes drop
      offer(make_access(pcid_pkg::OPC_OUT32, 8'h00, pcid_pkg::PORT_ADDRESS, 32'hffff_ffff));
      offer(make_access(pcid_pkg::OPC_IN32, 8'h00, pcid_pkg::PORT_DATA, 32'h0));
      offer(make_access(pcid_pkg::OPC_OUT32, 8'h00, pcid_pkg::PORT_DATA, 32'h1234_5678));
      offer(make_access(pcid_pkg::OPC_IN8, 8'h00, pcid_pkg::PORT_DATA + 1, 32'h0));
      offer(make_access(pcid_pkg::OPC_IN32, 8'h00, pcid_pkg::PORT_ADDRESS, 32'h0));
      // reset request and ignored byte writes
      offer(make_access(pcid_pkg::OPC_OUT8, 8'h00, pcid_pkg::PORT_RESET, 32'h0000_0004));
      offer(make_access(pcid_pkg::OPC_OUT8, 8'h00, pcid_pkg::PORT_RESET, 32'hffff_fffb));
      offer(make_access(pcid_pkg::OPC_OUT8, 8'h00, pcid_pkg::PORT_DATA - 1, 32'hffff_ffff));
      offer(make_access(pcid_pkg::OPC_OUT8_IMM, 8'h00, pcid_pkg::PORT_RESET, 32'hffff_ffff));
      offer(make_access(pcid_pkg::OPC_OUT16[7:0], pcid_pkg::OPC_OUT16[15:8],
                        pcid_pkg::PORT_DATA, 32'hffff_ffff));
      offer(make_access(pcid_pkg::OPC_PIC_IN[7:0], pcid_pkg::OPC_PIC_IN[15:8],
                        32'h0, 32'h0));
      offer(make_access(pcid_pkg::OPC_PIC_IN[7:0], pcid_pkg::OPC_PIC_IN[15:8],
                        32'hffff_ffff, 32'hffff_ff00));
      // undecodable
      offer(make_access(8'h00, 8'h00, 32'h0, 32'h0));
      offer(make_access(8'hff, 8'hff, 32'hffff_ffff, 32'hffff_ffff));
      offer(make_access(pcid_pkg::OPC_IN16[7:0], 8'h00, pcid_pkg::PORT_DATA, 32'h0));

      for (int i = 0; i < ACCESS_COUNT; i++) offer(draw_access());
      req_valid <= 1'b0;

      drain_wait = 0;
      while (pending != 0 && drain_wait < 5000) begin
         @(negedge clock);
         drain_wait++;
      end
      repeat (16) @(negedge clock);

      $display("tb: %0d accesses checked, %0d data port writes, %0d store reads",
               checked, store_writes, store_reads);
      $display("tb: %0d reset requests, %0d undecodable, one %0d-cycle response hold-off",
               reset_requests, stops, PRESSURE_LEN);
      if (failures == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
